FILE: design/mrpt_pkg.sv
`timescale 1ns / 1ps

package mrpt_pkg;

    localparam int CAND_W    = 32;
    localparam int ROUNDS_W  = 6;
    localparam int SEED_W    = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int MUL_STEPS = CAND_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    localparam logic [ROUNDS_W-1:0] RESET_ROUNDS = ROUNDS_W'(10);
    localparam logic [SEED_W-1:0]   RESET_SEED   = SEED_W'(1);

    localparam logic REG_ROUNDS = 1'b0;
    localparam logic REG_SEED   = 1'b1;

    // operand routing for the shared modular multiplier
    typedef enum logic [1:0] {
        MUL_WIT  = 2'd0,   // rng mod (n-1)
        MUL_R    = 2'd1,   // acc * base mod n
        MUL_BASE = 2'd2,   // base * base mod n
        MUL_SQ   = 2'd3    // acc * acc mod n
    } mrpt_mul_sel_t;

    typedef struct packed {
        logic          we;
        logic          idx;
        logic [DATA_W-1:0] data;
    } mrpt_cfg_t;

    typedef struct packed {
        logic          load_cand;
        logic          split_init;
        logic          split_step;
        logic          round_clear;
        logic          round_inc;
        logic          rng_step;
        logic          mul_start;
        mrpt_mul_sel_t mul_sel;
        logic          wit_load;
        logic          acc_from_mul;
        logic          base_from_mul;
        logic          e_shift;
        logic          sq_init;
        logic          sq_step;
        logic          set_verdict;
        logic          verdict;
        logic          load_out;
    } mrpt_cmd_t;

    typedef struct packed {
        logic trivial;
        logic trivial_val;
        logic m_even;
        logic rounds_done;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
        logic sq_done;
        logic acc_one;
        logic sq_bad;
    } mrpt_stat_t;

endpackage

FILE: design/miller_rabin_prime_test.sv
`timescale 1ns / 1ps

// Miller-Rabin probable-prime test. One 32-bit two's complement candidate per
// request; one verdict bit back (1 probably prime, 0 composite). Negative
// values, values at or above 2^VALUE_BITS, values below 2 and even values
// other than 2 are answered by the check alone, with no round. An odd
// candidate n runs `rounds` rounds with witnesses from a xorshift32 generator
// that carries over from one request to the next; writing rng_seed (address 4)
// reloads it, rounds lies at address 0. All modular arithmetic goes through
// one shared shift-add modular multiplier: each round reduces the generator
// value mod n-1 to pick the witness, raises it to m by square-and-multiply and
// squares the result k times, where n-1 = m * 2^k. Most composites finish
// inside the first round.
// A new candidate is accepted once the previous verdict sits in the output
// register.
module miller_rabin_prime_test #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrpt_pkg::ADDR_W-1:0]   paddr,
    input  logic [mrpt_pkg::DATA_W-1:0]   pwdata,
    output logic [mrpt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [mrpt_pkg::CAND_W-1:0] candidate,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_prime
);
    import mrpt_pkg::*;

    mrpt_cfg_t  cfg;
    mrpt_cmd_t  cmd;
    mrpt_stat_t stat;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite;
    assign cfg.idx  = paddr[2];
    assign cfg.data = pwdata;

    mrpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mrpt_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_rdata (prdata),
        .candidate (candidate),
        .cmd       (cmd),
        .stat      (stat),
        .is_prime  (is_prime)
    );

endmodule

FILE: design/mrpt_mulmod.sv
`timescale 1ns / 1ps

module mrpt_mulmod #(
    parameter int VALUE_BITS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [VALUE_BITS-1:0]          modulus,
    input  logic [VALUE_BITS-1:0]          op_a,
    input  logic [mrpt_pkg::CAND_W-1:0]    op_b,
    output logic                           done,
    output logic [VALUE_BITS-1:0]          result
);
    import mrpt_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] mod_reg, mod_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [CAND_W-1:0]     b_reg, b_next;
    logic [VALUE_BITS-1:0] r_reg, r_next;

    logic [VALUE_BITS:0] dbl, dbl_red, sum, sum_red, mod_ext;

    // Horner step, MSB of b first: r = 2r + bit*a, both reduced by one subtract
    always_comb
    begin
        mod_ext = {1'b0, mod_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
        sum     = dbl_red + (b_reg[CAND_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mod_next  = modulus;
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red[VALUE_BITS-1:0];
            b_next   = {b_reg[CAND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg <= mod_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

FILE: design/mrpt_dp.sv
`timescale 1ns / 1ps

module mrpt_dp #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrpt_pkg::mrpt_cfg_t           cfg,
    output logic [mrpt_pkg::DATA_W-1:0]   cfg_rdata,
    input  logic [mrpt_pkg::CAND_W-1:0]   candidate,
    input  mrpt_pkg::mrpt_cmd_t           cmd,
    output mrpt_pkg::mrpt_stat_t          stat,
    output logic                          is_prime
);
    import mrpt_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int KW = $clog2(VB);

    logic [ROUNDS_W-1:0] rounds_reg, rounds_next;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic [SEED_W-1:0]   rng_reg, rng_next;
    logic [ROUNDS_W-1:0] rcnt_reg, rcnt_next;
    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic [VB-1:0]       m_reg, m_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       j_reg, j_next;
    logic [VB-1:0]       base_reg, base_next;
    logic [VB-1:0]       acc_reg, acc_next;
    logic [VB-1:0]       e_reg, e_next;
    logic                verdict_reg, verdict_next;
    logic                is_prime_reg, is_prime_next;

    logic [VB-1:0]       n_val, n_m1;
    logic                too_big;
    logic [SEED_W-1:0]   xs1, xs2, xs3;

    logic [VB-1:0]       mul_mod, mul_a;
    logic [CAND_W-1:0]   mul_b;
    logic                mul_done;
    logic [VB-1:0]       mul_res;

    assign n_val   = cand_reg[VB-1:0];
    assign n_m1    = n_val - VB'(1);
    assign too_big = |cand_reg[CAND_W-1:VB];

    assign xs1 = rng_reg ^ (rng_reg << XS_SHIFT_A);
    assign xs2 = xs1 ^ (xs1 >> XS_SHIFT_B);
    assign xs3 = xs2 ^ (xs2 << XS_SHIFT_C);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_WIT:
            begin
                mul_mod = n_m1;
                mul_a   = VB'(1);
                mul_b   = rng_reg;
            end
            MUL_R:
            begin
                mul_mod = n_val;
                mul_a   = base_reg;
                mul_b   = CAND_W'(acc_reg);
            end
            MUL_BASE:
            begin
                mul_mod = n_val;
                mul_a   = base_reg;
                mul_b   = CAND_W'(base_reg);
            end
            MUL_SQ:
            begin
                mul_mod = n_val;
                mul_a   = acc_reg;
                mul_b   = CAND_W'(acc_reg);
            end
            default:
            begin
                mul_mod = n_val;
                mul_a   = acc_reg;
                mul_b   = CAND_W'(acc_reg);
            end
        endcase
    end

    mrpt_mulmod #(
        .VALUE_BITS (VB)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .modulus (mul_mod),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb
    begin
        stat.trivial     = too_big || (n_val == VB'(2)) || (n_val[VB-1:1] == '0)
                           || !n_val[0];
        stat.trivial_val = !too_big && (n_val == VB'(2));
        stat.m_even      = !m_reg[0];
        stat.rounds_done = (rcnt_reg == rounds_reg);
        stat.mul_done    = mul_done;
        stat.e_zero      = (e_reg == '0);
        stat.e_lsb       = e_reg[0];
        stat.sq_done     = (j_reg == k_reg);
        stat.acc_one     = (acc_reg == VB'(1));
        // nontrivial square root of one
        stat.sq_bad      = (mul_res == VB'(1)) && (acc_reg != VB'(1))
                           && (acc_reg != n_m1);
    end

    always_comb
    begin
        rounds_next   = rounds_reg;
        seed_next     = seed_reg;
        rng_next      = rng_reg;
        rcnt_next     = rcnt_reg;
        cand_next     = cand_reg;
        m_next        = m_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        e_next        = e_reg;
        verdict_next  = verdict_reg;
        is_prime_next = is_prime_reg;

        if (cfg.we)
        begin
            if (cfg.idx == REG_ROUNDS)
            begin
                rounds_next = cfg.data[ROUNDS_W-1:0];
            end
            else
            begin
                seed_next = cfg.data[SEED_W-1:0];
                rng_next  = cfg.data[SEED_W-1:0];
            end
        end
        if (cmd.rng_step)
            rng_next = xs3;
        if (cmd.load_cand)
            cand_next = candidate;
        if (cmd.split_init)
        begin
            m_next = n_m1;
            k_next = '0;
        end
        if (cmd.split_step)
        begin
            m_next = m_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        if (cmd.round_clear)
            rcnt_next = '0;
        if (cmd.round_inc)
            rcnt_next = rcnt_reg + 1'b1;
        if (cmd.wit_load)
        begin
            base_next = mul_res + VB'(1);
            acc_next  = VB'(1);
            e_next    = m_reg;
        end
        if (cmd.acc_from_mul)
            acc_next = mul_res;
        if (cmd.base_from_mul)
            base_next = mul_res;
        if (cmd.e_shift)
            e_next = e_reg >> 1;
        if (cmd.sq_init)
            j_next = '0;
        if (cmd.sq_step)
        begin
            acc_next = mul_res;
            j_next   = j_reg + 1'b1;
        end
        if (cmd.set_verdict)
            verdict_next = cmd.verdict;
        if (cmd.load_out)
            is_prime_next = verdict_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_reg <= RESET_ROUNDS;
            seed_reg   <= RESET_SEED;
            rng_reg    <= RESET_SEED;
        end
        else
        begin
            rounds_reg <= rounds_next;
            seed_reg   <= seed_next;
            rng_reg    <= rng_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcnt_reg     <= rcnt_next;
        cand_reg     <= cand_next;
        m_reg        <= m_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        e_reg        <= e_next;
        verdict_reg  <= verdict_next;
        is_prime_reg <= is_prime_next;
    end

    assign cfg_rdata = (cfg.idx == REG_ROUNDS) ? DATA_W'(rounds_reg) : DATA_W'(seed_reg);
    assign is_prime  = is_prime_reg;

endmodule

FILE: design/mrpt_ctrl.sv
`timescale 1ns / 1ps

module mrpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mrpt_pkg::mrpt_stat_t  stat,
    output mrpt_pkg::mrpt_cmd_t   cmd
);
    import mrpt_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CHECK    = 11'b000_0000_0010,
        S_SPLIT    = 11'b000_0000_0100,
        S_ROUND    = 11'b000_0000_1000,
        S_WIT      = 11'b000_0001_0000,
        S_WIT_WAIT = 11'b000_0010_0000,
        S_POW      = 11'b000_0100_0000,
        S_POW_R    = 11'b000_1000_0000,
        S_POW_B    = 11'b001_0000_0000,
        S_SQ       = 11'b010_0000_0000,
        S_SQ_WAIT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_WIT;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    // hold the verdict until the output slot frees up
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                        done_next      = 1'b0;
                    end
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_cand = 1'b1;
                        state_next    = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.trivial)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = stat.trivial_val;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.split_init = 1'b1;
                    state_next     = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (stat.m_even)
                    cmd.split_step = 1'b1;
                else
                begin
                    cmd.round_clear = 1'b1;
                    state_next      = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (stat.rounds_done)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rng_step = 1'b1;
                    state_next   = S_WIT;
                end
            end
            S_WIT:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_WIT;
                state_next    = S_WIT_WAIT;
            end
            S_WIT_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.wit_load = 1'b1;
                    state_next   = S_POW;
                end
            end
            S_POW:
            begin
                if (stat.e_zero)
                begin
                    cmd.sq_init = 1'b1;
                    state_next  = S_SQ;
                end
                else if (stat.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_R;
                    state_next    = S_POW_R;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_BASE;
                    state_next    = S_POW_B;
                end
            end
            S_POW_R:
            begin
                if (stat.mul_done)
                begin
                    cmd.acc_from_mul = 1'b1;
                    cmd.mul_start    = 1'b1;
                    cmd.mul_sel      = MUL_BASE;
                    state_next       = S_POW_B;
                end
            end
            S_POW_B:
            begin
                if (stat.mul_done)
                begin
                    cmd.base_from_mul = 1'b1;
                    cmd.e_shift       = 1'b1;
                    state_next        = S_POW;
                end
            end
            S_SQ:
            begin
                if (stat.sq_done)
                begin
                    if (!stat.acc_one)
                    begin
                        cmd.set_verdict = 1'b1;
                        cmd.verdict     = 1'b0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.round_inc = 1'b1;
                        state_next    = S_ROUND;
                    end
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQ;
                    state_next    = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT:
            begin
                if (stat.mul_done)
                begin
                    if (stat.sq_bad)
                    begin
                        cmd.set_verdict = 1'b1;
                        cmd.verdict     = 1'b0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.sq_step = 1'b1;
                        state_next  = S_SQ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                done_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: tb/miller_rabin_prime_test_test.sv
`timescale 1ns / 1ps

module miller_rabin_prime_test_test;

    import mrpt_pkg::*;

    localparam int VALUE_BITS    = 31;
    localparam int STALL_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 28;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 16;
    localparam int DIRECTED_ROWS = 26;

    localparam logic [ADDR_W-1:0] ADDR_ROUNDS = {REG_ROUNDS, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SEED   = {REG_SEED, 2'b00};

    typedef enum logic [1:0] {
        ROW_CAND,
        ROW_ROUNDS,
        ROW_SEED
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        known;
        logic        verdict;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] cand;
        logic        verdict;
    } verdict_entry_t;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic signed [CAND_W-1:0] candidate = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              is_prime;

    // predictor copy of the block's configuration and generator
    logic [ROUNDS_W-1:0] rounds_cfg;
    logic [SEED_W-1:0]   rng_state;

    verdict_entry_t verdicts_due[$];
    int             mismatches = 0;
    int             stall_cycles = 0;
    logic           steady = 1'b0;

    miller_rabin_prime_test #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .candidate(candidate),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_prime(is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] mulmod(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] n);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return 32'(prod % {32'd0, n});
    endfunction

    function automatic logic [31:0] powmod(input logic [31:0] base, input logic [31:0] e,
                                           input logic [31:0] n);
        logic [31:0] acc;
        logic [31:0] b;
        logic [31:0] ex;
        acc = 32'd1 % n;
        b = base;
        ex = e;
        while (ex != 0)
        begin
            if (ex[0])
                acc = mulmod(acc, b, n);
            b = mulmod(b, b, n);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // advance xorshift32 and map into 1..n-1
    function automatic logic [31:0] draw_witness(input logic [31:0] n);
        logic [31:0] x;
        x = rng_state;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        rng_state = x;
        return x % (n - 32'd1) + 32'd1;
    endfunction

    function automatic logic primality_verdict(input logic [31:0] raw);
        logic [31:0] n;
        logic [31:0] m;
        logic [31:0] x;
        logic [31:0] y;
        int          k;
        if (raw[31])
            return 1'b0;
        if ({1'b0, raw} >= (33'd1 << VALUE_BITS))
            return 1'b0;
        n = raw;
        if (n == 32'd2)
            return 1'b1;
        if (n < 32'd2 || !n[0])
            return 1'b0;
        m = n - 32'd1;
        k = 0;
        while (!m[0])
        begin
            m = m >> 1;
            k++;
        end
        for (int r = 0; r < int'(rounds_cfg); r++)
        begin
            x = powmod(draw_witness(n), m, n);
            y = x;
            for (int j = 0; j < k; j++)
            begin
                y = mulmod(x, x, n);
                // nontrivial square root of one
                if (y == 32'd1 && x != 32'd1 && x != n - 32'd1)
                    return 1'b0;
                x = y;
            end
            if (y != 32'd1)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_candidate(input logic big_ok);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return $urandom;
        if (sel < 15)
            return {1'b1, 31'($urandom)};
        if (sel < 25)
            return $urandom & 32'h0000_1FFE;
        if (sel < 32 && big_ok)
            return {2'b01, 30'($urandom)} | 32'd1;
        if (sel < 45)
            return 32'($urandom_range(1, 31)) * 2 + 1;
        return 32'($urandom_range(1, 2047)) * 2 + 1;
    endfunction

    task automatic send_candidate(input logic [31:0] value, input logic known,
                                  input logic verdict);
        verdict_entry_t entry;
        logic           predicted;
        if (!steady && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = primality_verdict(value);
        entry.cand = value;
        entry.verdict = known ? verdict : predicted;
        verdicts_due.push_back(entry);
    endtask

    // drop the request, then wait for every pending verdict before touching the registers
    task automatic drain;
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value,
                                  input logic [31:0] readback);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback)
        begin
            $display("%0t: register %0d readback mismatch: expected %h, got %h",
                     $time, addr, readback, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_rounds(input logic [31:0] value);
        drain();
        write_register(ADDR_ROUNDS, value, {26'd0, value[ROUNDS_W-1:0]});
        rounds_cfg = value[ROUNDS_W-1:0];
    endtask

    task automatic set_seed(input logic [31:0] value);
        drain();
        write_register(ADDR_SEED, value, value);
        rng_state = value;
    endtask

    // receiver: random backpressure plus one long hold-off
    initial
    begin : receiver
        int verdicts_seen;
        int hold_left;
        logic held_once;
        verdicts_seen = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                verdicts_seen++;
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held_once && verdicts_seen == HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected verdict %0d", $time, is_prime);
                    mismatches++;
                end
                else
                begin
                    if (is_prime !== verdicts_due[0].verdict)
                    begin
                        $display("%0t: is_prime mismatch for candidate %0d: expected %0d, got %0d",
                                 $time, $signed(verdicts_due[0].cand),
                                 verdicts_due[0].verdict, is_prime);
                        mismatches++;
                    end
                    void'(verdicts_due.pop_front());
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
                $display("miller_rabin_prime_test regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t rows [DIRECTED_ROWS];
        logic      big_ok;
        logic [31:0] phase_rounds;
        rounds_cfg = RESET_ROUNDS;
        rng_state  = RESET_SEED;
        rows = '{
            '{ROW_CAND,   32'd0,           1'b1, 1'b0},
            '{ROW_CAND,   32'd1,           1'b1, 1'b0},
            '{ROW_CAND,   32'd2,           1'b1, 1'b1},
            '{ROW_CAND,   32'd4,           1'b1, 1'b0},
            '{ROW_CAND,   32'hFFFF_FFFF,   1'b1, 1'b0},
            '{ROW_CAND,   32'h8000_0000,   1'b1, 1'b0},
            '{ROW_CAND,   32'd3,           1'b0, 1'b0},
            '{ROW_CAND,   32'd9,           1'b0, 1'b0},
            '{ROW_CAND,   32'd561,         1'b0, 1'b0},
            '{ROW_CAND,   32'h7FFF_FFFF,   1'b0, 1'b0},
            '{ROW_CAND,   32'h7FFF_FFFE,   1'b1, 1'b0},
            '{ROW_CAND,   32'h7FFF_FFFD,   1'b0, 1'b0},
            '{ROW_ROUNDS, 32'd0,           1'b0, 1'b0},
            '{ROW_CAND,   32'd15,          1'b1, 1'b1},
            '{ROW_CAND,   32'h7FFF_FFFF,   1'b1, 1'b1},
            '{ROW_ROUNDS, 32'd1,           1'b0, 1'b0},
            '{ROW_SEED,   32'd0,           1'b0, 1'b0},
            '{ROW_CAND,   32'd9,           1'b1, 1'b1},
            '{ROW_CAND,   32'd7,           1'b1, 1'b1},
            '{ROW_SEED,   32'hFFFF_FFFF,   1'b0, 1'b0},
            '{ROW_ROUNDS, 32'd32,          1'b0, 1'b0},
            '{ROW_CAND,   32'd97,          1'b0, 1'b0},
            '{ROW_CAND,   32'd91,          1'b0, 1'b0},
            '{ROW_ROUNDS, 32'd63,          1'b0, 1'b0},
            '{ROW_CAND,   32'd13,          1'b0, 1'b0},
            '{ROW_CAND,   32'd25,          1'b0, 1'b0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            case (rows[i].kind)
                ROW_ROUNDS: set_rounds(rows[i].value);
                ROW_SEED:   set_seed(rows[i].value);
                default:    send_candidate(rows[i].value, rows[i].known, rows[i].verdict);
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_rounds = 32'(RESET_ROUNDS);
                1: phase_rounds = 32'd1;
                2: phase_rounds = 32'd32;
                default: phase_rounds = 32'($urandom_range(2, 12));
            endcase
            set_rounds(phase_rounds);
            if (p == 0)
                set_seed(32'(RESET_SEED));
            else
                set_seed($urandom | 32'd1);
            // one phase runs with no idling on either side
            steady = (p == 3);
            // keep full-width odd values to short round counts
            big_ok = (phase_rounds <= 12);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_candidate(pick_candidate(big_ok), 1'b0, 1'b0);
        end

        drain();
        steady = 1'b0;
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("miller_rabin_prime_test regression: pass");
        else
            $display("miller_rabin_prime_test regression: fail");
        $finish;
    end

endmodule
